// ----- rtl/fcf_pkg.sv -----
// ----------------------------------------------------------------------------
// fcf_pkg
// Shared types and constants for the allocation-table chain free block.
// ----------------------------------------------------------------------------
package fcf_pkg;

   localparam int FAT_ENTRIES = 4096;
   localparam int ADDR_W = $clog2(FAT_ENTRIES);
   localparam logic [16:0] FAT_LIMIT = 17'(FAT_ENTRIES);

   localparam logic [15:0] END_MARK = 16'hFFFF;
   localparam logic [15:0] FIRST_DATA_BLOCK = 16'd5;
   localparam logic [15:0] FREE_WORD = 16'd3;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ = 2'd1;
   localparam logic [1:0] FUNC_FREE = 2'd2;

   localparam logic CSR_CARD_PRESENT = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_READY = 2'd0,
      STATUS_NO_CARD = 2'd1,
      STATUS_BROKEN = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] index;
      logic [15:0] write_data;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] read_data;
      logic [15:0] free_count;
   } rsp_payload_type;

   typedef struct packed {
      logic       capture;
      logic       write_word;
      logic       read_issue;
      logic       read_capture;
      logic       walk_read;
      logic       walk_link;
      logic       set_status;
      status_type status_code;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic       card;
      logic [1:0] func;
      logic       link_end;
      logic       link_bad;
      logic       rsp_busy;
   } stat_type;

endpackage

// ----- rtl/fat_chain_free.sv -----
// ----------------------------------------------------------------------------
// fat_chain_free
// Allocation-table keeper: table word load and read, and chain free.
// ----------------------------------------------------------------------------
// channel  ports                                   direction
// req      req_valid / req_ready / req_payload     in   func, index, write_data
// rsp      rsp_valid / rsp_ready / rsp_payload     out  status, read_data, free_count
// csr      csr_valid / csr_ready / csr_index,      in   0 card_present, 1 block_count
//          csr_write_data
//
// One transaction at a time. A free walks the chain with one memory read then one
// memory write per link freed, the write clearing that link's table word to 0.
// Reset clears control and configuration; table contents are undefined until
// loaded. A stalled rsp holds its result; the next req is taken once the
// result register is loaded.
// ----------------------------------------------------------------------------
module fat_chain_free (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  fcf_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output fcf_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [12:0]              csr_write_data
);
   import fcf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   fcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fcf_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

// ----- rtl/fcf_ctrl.sv -----
// ----------------------------------------------------------------------------
// fcf_ctrl
// Sequencer for table loads, reads and chain frees.
// ----------------------------------------------------------------------------
module fcf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fcf_pkg::stat_type stat,
   output fcf_pkg::cmd_type  cmd
);
   import fcf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RD_WAIT,
      S_CHECK,
      S_LINK,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.status_code = STATUS_READY;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!stat.card) begin
               cmd.set_status = 1'b1;
               cmd.status_code = STATUS_NO_CARD;
               state_in = S_FINISH;
            end else begin
               case (stat.func)
                  FUNC_WRITE: begin
                     cmd.write_word = 1'b1;
                     state_in = S_FINISH;
                  end
                  FUNC_READ: begin
                     cmd.read_issue = 1'b1;
                     state_in = S_RD_WAIT;
                  end
                  FUNC_FREE: begin
                     state_in = S_CHECK;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            cmd.read_capture = 1'b1;
            state_in = S_FINISH;
         end
         S_CHECK: begin
            if (stat.link_end) begin
               state_in = S_FINISH;
            end else if (stat.link_bad) begin
               cmd.set_status = 1'b1;
               cmd.status_code = STATUS_BROKEN;
               state_in = S_FINISH;
            end else begin
               cmd.walk_read = 1'b1;
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            cmd.walk_link = 1'b1;
            state_in = S_CHECK;
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/fcf_dpath.sv -----
// ----------------------------------------------------------------------------
// fcf_dpath
// Table memory, free counter shadow, link checks and result register.
// ----------------------------------------------------------------------------
module fcf_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  fcf_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output fcf_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   input  logic                     csr_index,
   input  logic [12:0]              csr_write_data,
   input  fcf_pkg::cmd_type         cmd,
   output fcf_pkg::stat_type        stat
);
   import fcf_pkg::*;

   logic [15:0] mem [FAT_ENTRIES];
   logic [15:0] mem_q_ff;

   logic        card_ff;
   logic [12:0] bcnt_ff;
   logic [1:0]  func_ff;
   logic [15:0] idx_ff;
   logic [15:0] wdata_ff;
   logic [15:0] blk_ff;
   logic [1:0]  status_ff;
   logic [15:0] rdata_ff;
   logic [15:0] free_ff;
   logic        rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic              idx_ok;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] mem_raddr;
   logic [15:0]       mem_wdata;

   assign idx_ok = ({1'b0, idx_ff} < FAT_LIMIT);

   assign mem_we = (cmd.write_word && idx_ok) || cmd.walk_link;
   assign mem_waddr = cmd.walk_link ? blk_ff[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
   assign mem_wdata = cmd.walk_link ? 16'd0 : wdata_ff;
   assign mem_raddr = cmd.walk_read ? blk_ff[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.read_issue || cmd.walk_read) begin
         mem_q_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         card_ff <= 1'b0;
         bcnt_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_CARD_PRESENT) begin
            card_ff <= csr_write_data[0];
         end else begin
            bcnt_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_payload.func;
         idx_ff <= req_payload.index;
         wdata_ff <= req_payload.write_data;
         blk_ff <= req_payload.index;
         status_ff <= STATUS_READY;
         rdata_ff <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.walk_link) begin
            blk_ff <= mem_q_ff;
         end
         if (cmd.read_capture && idx_ok) begin
            rdata_ff <= (idx_ff == FREE_WORD) ? free_ff : mem_q_ff;
         end
      end
   end

   // word 3 is kept in flops, the memory copy is stale after frees
   always_ff @(posedge clock) begin
      if (cmd.write_word && idx_ok && (idx_ff == FREE_WORD)) begin
         free_ff <= wdata_ff;
      end else if (cmd.walk_link) begin
         free_ff <= free_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.status <= status_ff;
         rsp_ff.read_data <= rdata_ff;
         rsp_ff.free_count <= free_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign stat.card = card_ff;
   assign stat.func = func_ff;
   assign stat.link_end = (blk_ff == END_MARK);
   assign stat.link_bad = (blk_ff < FIRST_DATA_BLOCK) || ({3'b000, bcnt_ff} <= blk_ff) ||
                          ({1'b0, blk_ff} >= FAT_LIMIT);
   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;

endmodule
